>>> sv/assert_macros.svh
// Assertion macros of the checker file of the reverse bit reader.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define ZRBR_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("zrbr: property failed");

// Check that a condition is followed by a consequence in the next cycle
`define ZRBR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("zrbr: sequence property failed");

`endif

>>> sv/zrbr_pkg.sv
// Package of the reverse bit reader: sizes, command and error codes,
// controller states and the controller/datapath command and status structs.
`default_nettype none

package zrbr_pkg;

    // Store and field sizes
    localparam int STORE_BYTES    = 4096;
    localparam int ADDR_W         = $clog2(STORE_BYTES);
    localparam int BYTE_ADDR_W    = 12;
    localparam int BYTE_W         = 8;
    localparam int POS_W          = 13;
    localparam int MAX_FIELD_BITS = 32;
    localparam int CNT_W          = 6;
    localparam int BUF_W          = 6;
    localparam int ACC_W          = 40;
    localparam int CMD_W          = 3;
    localparam int ERR_W          = 3;
    localparam int REM_W          = 16;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 13;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SPAN_BEGIN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPAN_END   = 1'd1;

    typedef enum logic [CMD_W-1:0] {
        OP_WRITE    = 3'd0,
        OP_START    = 3'd1,
        OP_READ     = 3'd2,
        OP_PEEK     = 3'd3,
        OP_PAD_PEEK = 3'd4,
        OP_DISCARD  = 3'd5
    } t_op;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK         = 3'd0,
        ERR_EMPTY_SPAN = 3'd1,
        ERR_NO_MARKER  = 3'd2,
        ERR_TRUNCATED  = 3'd3,
        ERR_DISCARD    = 3'd4,
        ERR_LOOKAHEAD  = 3'd5
    } t_err;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_START_WAIT,
        S_FILL,
        S_FILL_WAIT,
        S_EXTRACT,
        S_DONE
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic latch;
        logic mem_wr;
        logic rd_start;
        logic rd_fill;
        logic set_err;
        t_err err;
        logic make_empty;
        logic start_load;
        logic fill_shift;
        logic extract;
        logic discard;
        logic load_out;
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic [CMD_W-1:0] op;
        logic             cnt_over;
        logic             span_bad;
        logic             discard_bad;
        logic             marker_zero;
        logic             need_fill;
        logic             out_free;
    } t_dp_sts;

    // Mask of the n low bits of a field word
    function automatic logic [MAX_FIELD_BITS-1:0] low_mask(input logic [CNT_W-1:0] n);
        logic [MAX_FIELD_BITS:0] m;
        m = ({{MAX_FIELD_BITS{1'b0}}, 1'b1} << n) - {{MAX_FIELD_BITS{1'b0}}, 1'b1};
        if (n >= CNT_W'(MAX_FIELD_BITS)) begin
            return '1;
        end
        return m[MAX_FIELD_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

>>> sv/zrbr_if.sv
// Valid/ready channel interfaces of the reverse bit reader: command words
// in, result words out. Depends on zrbr_pkg.
`default_nettype none

interface zrbr_in_if import zrbr_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic [CMD_W-1:0]       cmd;
    logic [BYTE_ADDR_W-1:0] byte_address;
    logic [BYTE_W-1:0]      byte_value;
    logic [CNT_W-1:0]       bit_count;

    modport source (output valid, cmd, byte_address, byte_value, bit_count, input ready);
    modport sink   (input valid, cmd, byte_address, byte_value, bit_count, output ready);
endinterface

interface zrbr_out_if import zrbr_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic [MAX_FIELD_BITS-1:0] bits_value;
    logic [ERR_W-1:0]          error_code;
    logic [REM_W-1:0]          bits_remaining;
    logic                      at_end;

    modport source (output valid, bits_value, error_code, bits_remaining, at_end,
                    input ready);
    modport sink   (input valid, bits_value, error_code, bits_remaining, at_end,
                    output ready);
endinterface

`default_nettype wire

>>> sv/zrbr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module zrbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> sv/zrbr_datapath.sv
// Datapath of the reverse bit reader: byte store, accumulator, positions,
// span registers and the result word register. Depends on zrbr_pkg, zrbr_ram.
`default_nettype none

module zrbr_datapath import zrbr_pkg::*; (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire t_dp_cmd                   i_ctl,
    output t_dp_sts                        o_sts,
    input  wire logic                      i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]     i_cfg_data,
    input  wire logic [CMD_W-1:0]          i_cmd,
    input  wire logic [BYTE_ADDR_W-1:0]    i_byte_address,
    input  wire logic [BYTE_W-1:0]         i_byte_value,
    input  wire logic [CNT_W-1:0]          i_bit_count,
    input  wire logic                      i_out_ready,
    output logic                           o_out_valid,
    output logic [MAX_FIELD_BITS-1:0]      o_bits_value,
    output logic [ERR_W-1:0]               o_error_code,
    output logic [REM_W-1:0]               o_bits_remaining,
    output logic                           o_at_end
);

    // Latched command word
    logic [CMD_W-1:0]       r_op;
    logic [BYTE_ADDR_W-1:0] r_addr;
    logic [BYTE_W-1:0]      r_val;
    logic [CNT_W-1:0]       r_cnt;

    // Span registers and reader state
    logic [POS_W-1:0] r_span_begin, r_span_end;
    logic [ACC_W-1:0] r_acc, n_acc;
    logic [BUF_W-1:0] r_buf, n_buf;
    logic [POS_W-1:0] r_rp, n_rp;
    logic [POS_W-1:0] r_sb, n_sb;

    // Result under construction and result word register
    logic [MAX_FIELD_BITS-1:0] r_bits, n_bits;
    logic [ERR_W-1:0]          r_err, n_err;
    logic                      r_out_valid;
    logic [MAX_FIELD_BITS-1:0] r_out_bits;
    logic [ERR_W-1:0]          r_out_err;
    logic [REM_W-1:0]          r_out_rem;
    logic                      r_out_end;

    logic [BYTE_W-1:0] ram_rdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic              ram_we;
    logic [POS_W-1:0]  span_last;
    logic [2:0]        hb;
    logic [BYTE_W-1:0] marker_cleared;
    logic [BUF_W-1:0]  shift_amt;
    logic [ACC_W-1:0]  window;
    logic [MAX_FIELD_BITS-1:0] pad_bits;
    logic [REM_W-1:0]  remaining;
    logic              at_end;

    // Byte store
    assign ram_we    = i_ctl.mem_wr && (POS_W'(r_addr) < POS_W'(STORE_BYTES));
    assign span_last = r_span_end - POS_W'(1);
    assign ram_raddr = i_ctl.rd_start ? ADDR_W'(span_last) : ADDR_W'(r_rp - POS_W'(1));

    zrbr_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(STORE_BYTES)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ADDR_W'(r_addr)),
        .i_wdata(r_val),
        .i_re   (i_ctl.rd_start || i_ctl.rd_fill),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // Find the end marker and drop it
    always_comb begin
        hb = 3'd0;
        for (int i = 0; i < BYTE_W; i++) begin
            if (ram_rdata[i]) begin
                hb = 3'(i);
            end
        end
        marker_cleared = ram_rdata & ~(BYTE_W'(1) << hb);
    end

    // Field extraction from the top of the buffered bits
    assign shift_amt = r_buf - r_cnt;
    assign window    = r_acc >> shift_amt;
    assign pad_bits  = (r_acc[MAX_FIELD_BITS-1:0] & low_mask(r_buf)) << (r_cnt - r_buf);

    // Status word fields
    assign remaining = REM_W'(r_buf) + {r_rp - r_sb, 3'b000};
    assign at_end    = (r_buf == '0) && (r_rp == r_sb);

    // Next reader state
    always_comb begin
        n_acc  = r_acc;
        n_buf  = r_buf;
        n_rp   = r_rp;
        n_sb   = r_sb;
        n_bits = r_bits;
        n_err  = r_err;
        if (i_ctl.latch) begin
            n_bits = '0;
            n_err  = ERR_OK;
        end
        if (i_ctl.set_err) begin
            n_err = i_ctl.err;
        end
        if (i_ctl.make_empty) begin
            n_acc = '0;
            n_buf = '0;
            n_rp  = '0;
            n_sb  = '0;
        end
        if (i_ctl.start_load) begin
            n_acc = ACC_W'(marker_cleared);
            n_buf = BUF_W'(hb);
            n_rp  = span_last;
            n_sb  = r_span_begin;
        end
        if (i_ctl.rd_fill) begin
            n_rp = r_rp - POS_W'(1);
        end
        if (i_ctl.fill_shift) begin
            n_acc = {r_acc[ACC_W-BYTE_W-1:0], ram_rdata};
            n_buf = r_buf + BUF_W'(BYTE_W);
        end
        if (i_ctl.discard) begin
            n_buf = r_buf - r_cnt;
        end
        if (i_ctl.extract) begin
            if (r_buf >= r_cnt) begin
                n_bits = window[MAX_FIELD_BITS-1:0] & low_mask(r_cnt);
                if (r_op == OP_READ) begin
                    n_buf = r_buf - r_cnt;
                end
            end else if (r_op == OP_PAD_PEEK) begin
                n_bits = pad_bits;
            end else begin
                n_err = ERR_TRUNCATED;
            end
        end
    end

    // Reader state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_buf <= '0;
            r_rp  <= '0;
            r_sb  <= '0;
        end else begin
            r_acc <= n_acc;
            r_buf <= n_buf;
            r_rp  <= n_rp;
            r_sb  <= n_sb;
        end
    end

    // Hold command word and partial result
    always_ff @(posedge i_clk) begin
        if (i_ctl.latch) begin
            r_op   <= i_cmd;
            r_addr <= i_byte_address;
            r_val  <= i_byte_value;
            r_cnt  <= i_bit_count;
        end
        r_bits <= n_bits;
        r_err  <= n_err;
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_span_begin <= '0;
            r_span_end   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SPAN_BEGIN: r_span_begin <= i_cfg_data;
                CFG_SPAN_END:   r_span_end   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Result word register: load on command, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_out) begin
            r_out_bits <= r_bits;
            r_out_err  <= r_err;
            r_out_rem  <= remaining;
            r_out_end  <= at_end;
        end
    end

    // Status to the controller
    assign o_sts.op          = r_op;
    assign o_sts.cnt_over    = r_cnt > CNT_W'(MAX_FIELD_BITS);
    assign o_sts.span_bad    = (r_span_begin >= r_span_end) ||
                               (r_span_end > POS_W'(STORE_BYTES));
    assign o_sts.discard_bad = r_cnt > r_buf;
    assign o_sts.marker_zero = ram_rdata == '0;
    assign o_sts.need_fill   = (r_buf < r_cnt) && (r_rp > r_sb);
    assign o_sts.out_free    = !r_out_valid || i_out_ready;

    assign o_out_valid      = r_out_valid;
    assign o_bits_value     = r_out_bits;
    assign o_error_code     = r_out_err;
    assign o_bits_remaining = r_out_rem;
    assign o_at_end         = r_out_end;

endmodule

`default_nettype wire

>>> sv/zrbr_ctrl.sv
// Controller state machine of the reverse bit reader: sequences one command
// word at a time through the datapath. Depends on zrbr_pkg.
`default_nettype none

module zrbr_ctrl import zrbr_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_ctl
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (i_sts.op)
                    OP_START: begin
                        n_state = i_sts.span_bad ? S_DONE : S_START_WAIT;
                    end
                    OP_READ, OP_PEEK, OP_PAD_PEEK: begin
                        n_state = i_sts.cnt_over ? S_DONE : S_FILL;
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_START_WAIT: n_state = S_DONE;
            S_FILL: begin
                n_state = i_sts.need_fill ? S_FILL_WAIT : S_EXTRACT;
            end
            S_FILL_WAIT: n_state = S_FILL;
            S_EXTRACT:   n_state = S_DONE;
            S_DONE: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath commands
    always_comb begin
        o_ctl      = '0;
        o_ctl.err  = ERR_OK;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_ctl.latch = i_in_valid;
            end
            S_EXEC: begin
                case (i_sts.op)
                    OP_WRITE: o_ctl.mem_wr = 1'b1;
                    OP_START: begin
                        if (i_sts.span_bad) begin
                            o_ctl.make_empty = 1'b1;
                            o_ctl.set_err    = 1'b1;
                            o_ctl.err        = ERR_EMPTY_SPAN;
                        end else begin
                            o_ctl.rd_start = 1'b1;
                        end
                    end
                    OP_READ, OP_PEEK: begin
                        if (i_sts.cnt_over) begin
                            o_ctl.set_err = 1'b1;
                            o_ctl.err     = ERR_TRUNCATED;
                        end
                    end
                    OP_PAD_PEEK: begin
                        if (i_sts.cnt_over) begin
                            o_ctl.set_err = 1'b1;
                            o_ctl.err     = ERR_LOOKAHEAD;
                        end
                    end
                    OP_DISCARD: begin
                        if (i_sts.discard_bad) begin
                            o_ctl.set_err = 1'b1;
                            o_ctl.err     = ERR_DISCARD;
                        end else begin
                            o_ctl.discard = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            S_START_WAIT: begin
                if (i_sts.marker_zero) begin
                    o_ctl.make_empty = 1'b1;
                    o_ctl.set_err    = 1'b1;
                    o_ctl.err        = ERR_NO_MARKER;
                end else begin
                    o_ctl.start_load = 1'b1;
                end
            end
            S_FILL:      o_ctl.rd_fill    = i_sts.need_fill;
            S_FILL_WAIT: o_ctl.fill_shift = 1'b1;
            S_EXTRACT:   o_ctl.extract    = 1'b1;
            S_DONE:      o_ctl.load_out   = i_sts.out_free;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

>>> sv/zstd_reverse_bit_reader_core.sv
// Top level of the Zstandard backward bitstream reader.
// Depends on zrbr_pkg, zrbr_if, zrbr_ctrl, zrbr_datapath, zrbr_ram.
//
// Usage:
//   i_in carries command words (write byte, start, read, peek, padded peek,
//   discard); o_out returns one result word per command word.
//   Span registers are written on the plain write port (i_cfg_we, i_cfg_index,
//   i_cfg_data); the user must write them only while no command is in flight,
//   since the block itself does not enforce it. One command word is processed
//   at a time. Write, discard, unused codes and counts above 32 go from S_EXEC
//   to S_DONE; start passes S_START_WAIT to load the last span byte; read and
//   peeks loop through S_FILL and S_FILL_WAIT once per refilled byte (0 to 4
//   bytes), then S_EXTRACT. The next word can be accepted in the cycle after
//   the result loads. The refill cost is set by the single registered read
//   port of the byte store, one byte per fetch and shift step.
//   A new command word is accepted while the previous result still waits;
//   when the receiver stalls, the controller holds the next result in S_DONE
//   until the result register is free.
//   Reset (synchronous, active low) empties the reader and clears the span
//   registers; the byte store is not cleared and must be written before use.

`default_nettype none

module zstd_reverse_bit_reader_core import zrbr_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    zrbr_in_if.sink                    i_in,
    zrbr_out_if.source                 o_out
);

    t_dp_cmd ctl;
    t_dp_sts sts;

    zrbr_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in.valid),
        .o_in_ready(i_in.ready),
        .i_sts     (sts),
        .o_ctl     (ctl)
    );

    zrbr_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (ctl),
        .o_sts           (sts),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_cmd           (i_in.cmd),
        .i_byte_address  (i_in.byte_address),
        .i_byte_value    (i_in.byte_value),
        .i_bit_count     (i_in.bit_count),
        .i_out_ready     (o_out.ready),
        .o_out_valid     (o_out.valid),
        .o_bits_value    (o_out.bits_value),
        .o_error_code    (o_out.error_code),
        .o_bits_remaining(o_out.bits_remaining),
        .o_at_end        (o_out.at_end)
    );

endmodule

`default_nettype wire

>>> sv/zrbr_checker.sv
// Port-level checker of the reverse bit reader and its bind to the top level.
// Depends on zrbr_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module zrbr_checker import zrbr_pkg::*; (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      i_in_valid,
    input wire logic                      i_in_ready,
    input wire logic                      i_out_valid,
    input wire logic                      i_out_ready,
    input wire logic [MAX_FIELD_BITS-1:0] i_bits_value,
    input wire logic [ERR_W-1:0]          i_error_code,
    input wire logic [REM_W-1:0]          i_bits_remaining,
    input wire logic                      i_at_end
);

    // A stalled result word holds
    `ZRBR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_bits_value) && $stable(i_error_code))

    // Only one command word in flight: ready drops after an acceptance
    `ZRBR_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)

    // An error result carries no bits
    `ZRBR_ASSERT(a_err_no_bits, i_clk, i_rst_n, i_out_valid && (i_error_code != ERR_OK) |-> i_bits_value == '0)

    // End of stream means nothing remains
    `ZRBR_ASSERT(a_end_empty, i_clk, i_rst_n, i_out_valid && i_at_end |-> i_bits_remaining == '0)

endmodule

bind zstd_reverse_bit_reader_core zrbr_checker u_zrbr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_bits_value    (o_out.bits_value),
    .i_error_code    (o_out.error_code),
    .i_bits_remaining(o_out.bits_remaining),
    .i_at_end        (o_out.at_end)
);

`default_nettype wire
